>>> sv/pbg_pkg.sv
// Shared types, constants and helpers for the packed RAW10 Bayer to gray block.
package pbg_pkg;

  localparam int unsigned PIX_W           = 10;
  localparam int unsigned GRAY_W          = 8;
  localparam int unsigned PPK             = 4;
  localparam int unsigned PACK_W          = PIX_W * PPK;
  localparam int unsigned WP_W            = 10;
  localparam int unsigned HR_W            = 12;
  localparam int unsigned TOT_W           = WP_W + HR_W;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 12;
  localparam int unsigned MAX_WIDTH_PACKS_DEF = 512;
  localparam int unsigned MAX_HEIGHT_DEF  = 2048;

  localparam logic [WP_W-1:0] WP_RST = WP_W'(364);
  localparam logic [HR_W-1:0] HR_RST = HR_W'(1088);

  // Neighbor sum and divide-by-three reciprocal
  localparam int unsigned SUM_W   = PIX_W + 2;
  localparam int unsigned DIV3_W  = 12;
  localparam int unsigned PROD_W  = SUM_W + DIV3_W;
  localparam int unsigned DIV3_SH = 13;
  localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(2731);

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_PACKS = 2'd0,
    CFG_HEIGHT_ROWS = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD_C,
    SQ_RD_L,
    SQ_RD_R,
    SQ_RD_U,
    SQ_CAP,
    SQ_EMIT
  } seq_e;

  typedef struct packed {
    logic nb_left;
    logic nb_right;
    logic nb_up;
    logic nb_down;
  } nbr_mask_t;

  function automatic logic [PIX_W-1:0] pack_pix(input logic [PACK_W-1:0] p,
                                                input logic [1:0] k);
    return p[PACK_W - 1 - PIX_W * k -: PIX_W];
  endfunction

endpackage

>>> sv/pbg_hist_mem.sv
// Pack history ring memory: one write port, one registered read port.
module pbg_hist_mem #(
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned DW    = 40,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/pbg_lane.sv
// One pixel lane: green pass-through or truncated mean of in-bounds neighbors.
module pbg_lane import pbg_pkg::*; (
  input  logic [PIX_W-1:0]  cen_i,
  input  logic [PIX_W-1:0]  lft_i,
  input  logic [PIX_W-1:0]  rgt_i,
  input  logic [PIX_W-1:0]  up_i,
  input  logic [PIX_W-1:0]  dn_i,
  input  nbr_mask_t         mask_i,
  input  logic              green_i,
  output logic [GRAY_W-1:0] gray_o
);

  logic [SUM_W-1:0]  sum;
  logic [2:0]        cnt;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean;
  logic [PIX_W-1:0]  val;

  assign sum = ({SUM_W{mask_i.nb_left}}  & SUM_W'(lft_i)) +
               ({SUM_W{mask_i.nb_right}} & SUM_W'(rgt_i)) +
               ({SUM_W{mask_i.nb_up}}    & SUM_W'(up_i)) +
               ({SUM_W{mask_i.nb_down}}  & SUM_W'(dn_i));

  assign cnt  = 3'($countones(mask_i));
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

  always_comb begin
    case (cnt)
      3'd1:    mean = PIX_W'(sum);
      3'd2:    mean = PIX_W'(sum >> 1);
      3'd3:    mean = prod[DIV3_SH +: PIX_W];
      3'd4:    mean = PIX_W'(sum >> 2);
      default: mean = cen_i;
    endcase
  end

  assign val    = (green_i || (cnt == 3'd0)) ? cen_i : mean;
  assign gray_o = val[PIX_W-1 -: GRAY_W];

endmodule

>>> sv/packed_raw10_bayer_to_gray.sv
// Packed RAW10 BGGR raster to 8-bit gray, four pixel lanes per pack.
// An item that gives no result leaves the input free for the next one; an item that gives a result
// stalls the input for four reads on the single history read port, a capture and the emit (plus any output stall).
// A pack's result leaves one row of packs after it; drain items flush the last row.
// Reset: counters to zero, width_packs 364, height_rows 1088, output empty;
// the history memory is not cleared.
module packed_raw10_bayer_to_gray import pbg_pkg::*; #(
  parameter int unsigned MAX_WIDTH_PACKS = MAX_WIDTH_PACKS_DEF,
  parameter int unsigned MAX_HEIGHT      = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [PACK_W-1:0]     pack_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [GRAY_W-1:0]     gray0_o,
  output logic [GRAY_W-1:0]     gray1_o,
  output logic [GRAY_W-1:0]     gray2_o,
  output logic [GRAY_W-1:0]     gray3_o,
  output logic                  frame_last_o
);

  localparam int unsigned HIST_DEPTH = 2 * MAX_WIDTH_PACKS + 1;
  localparam int unsigned AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH_PACKS * MAX_HEIGHT + 1);
  localparam int unsigned COL_W = (MAX_WIDTH_PACKS > 1) ? $clog2(MAX_WIDTH_PACKS) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  seq_e state_q, state_d;

  logic [WP_W-1:0]   wp_q;
  logic [HR_W-1:0]   hr_q;
  logic [WP_W-1:0]   eff_w;
  logic [HR_W-1:0]   eff_h;
  logic [TOT_W-1:0]  tot_full;
  logic [CNT_W-1:0]  total;

  logic [CNT_W-1:0]  rcv_q, m_q;
  logic [COL_W-1:0]  ecol_q;
  logic [ROW_W-1:0]  erow_q;
  logic [AW-1:0]     wptr_q, eptr_q;

  logic [CNT_W:0]    rcv_inc, m_pw;
  logic              rcv_full, data_emit, drain_emit;
  logic              in_acc, do_write, emit_now;
  logic              cfg_wr, cfg_restart;
  logic              has_left, has_right, has_up, has_down, frame_end;

  logic [AW-1:0]     a_c, a_l, a_r, a_u;
  logic [AW:0]       up_diff;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [PACK_W-1:0] rd_data;
  logic              out_load;

  logic [PACK_W-1:0] cen_q, lft_q, rgt_q, up_q, dn_q;
  logic [GRAY_W-1:0] lane_gray [PPK];
  logic [GRAY_W-1:0] gray_q [PPK];
  logic              last_q;
  logic              out_valid_q;

  // Effective geometry
  assign eff_w = (wp_q == '0) ? WP_W'(1) :
                 (32'(wp_q) > MAX_WIDTH_PACKS) ? WP_W'(MAX_WIDTH_PACKS) : wp_q;
  assign eff_h = (hr_q == '0) ? HR_W'(1) :
                 (32'(hr_q) > MAX_HEIGHT) ? HR_W'(MAX_HEIGHT) : hr_q;
  assign tot_full = TOT_W'(eff_w) * TOT_W'(eff_h);
  assign total    = CNT_W'(tot_full);

  // Accept decisions
  assign rcv_full   = rcv_q >= total;
  assign rcv_inc    = (CNT_W+1)'(rcv_q) + 1'b1;
  assign m_pw       = (CNT_W+1)'(m_q) + (CNT_W+1)'(eff_w);
  assign data_emit  = (rcv_inc > (CNT_W+1)'(eff_w)) && (m_pw < rcv_inc);
  assign drain_emit = rcv_full && (m_q < total);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign do_write = in_acc && (op_i == OP_DATA) && !rcv_full;
  assign emit_now = in_acc && ((op_i == OP_DATA) ? (!rcv_full && data_emit) : drain_emit);

  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_wr && ((cfg_index_i == CFG_WIDTH_PACKS) ||
                                  (cfg_index_i == CFG_HEIGHT_ROWS));

  // Position flags of the pack being emitted
  assign has_left  = ecol_q != '0;
  assign has_right = (32'(ecol_q) + 1) < 32'(eff_w);
  assign has_up    = erow_q != '0;
  assign has_down  = (32'(erow_q) + 1) < 32'(eff_h);
  assign frame_end = ((CNT_W+1)'(m_q) + 1'b1) == (CNT_W+1)'(total);

  // Ring addresses around the emit pointer
  assign a_c     = eptr_q;
  assign a_l     = (eptr_q == '0) ? AW'(HIST_DEPTH - 1) : eptr_q - 1'b1;
  assign a_r     = (eptr_q == AW'(HIST_DEPTH - 1)) ? '0 : eptr_q + 1'b1;
  assign up_diff = {1'b0, eptr_q} - (AW+1)'(eff_w);
  assign a_u     = up_diff[AW] ? AW'(up_diff + (AW+1)'(HIST_DEPTH)) : AW'(up_diff);

  pbg_hist_mem #(
    .DEPTH (HIST_DEPTH),
    .DW    (PACK_W)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wptr_q),
    .wdata_i (pack_bits_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: if (emit_now) state_d = SQ_RD_C;
      SQ_RD_C: state_d = SQ_RD_L;
      SQ_RD_L: state_d = SQ_RD_R;
      SQ_RD_R: state_d = SQ_RD_U;
      SQ_RD_U: state_d = SQ_CAP;
      SQ_CAP:  state_d = SQ_EMIT;
      SQ_EMIT: if (out_load) state_d = SQ_IDLE;
      default: state_d = SQ_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = a_c;
    out_load    = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
      end
      SQ_RD_C: begin
        rd_en   = 1'b1;
        rd_addr = a_c;
      end
      SQ_RD_L: begin
        rd_en   = 1'b1;
        rd_addr = a_l;
      end
      SQ_RD_R: begin
        rd_en   = 1'b1;
        rd_addr = a_r;
      end
      SQ_RD_U: begin
        rd_en   = 1'b1;
        rd_addr = a_u;
      end
      SQ_EMIT: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Config and frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= WP_RST;
      hr_q   <= HR_RST;
      rcv_q  <= '0;
      m_q    <= '0;
      ecol_q <= '0;
      erow_q <= '0;
      wptr_q <= '0;
      eptr_q <= '0;
    end else if (cfg_restart) begin
      if (cfg_index_i == CFG_WIDTH_PACKS) begin
        wp_q <= cfg_wdata_i[WP_W-1:0];
      end else begin
        hr_q <= cfg_wdata_i[HR_W-1:0];
      end
      rcv_q  <= '0;
      m_q    <= '0;
      ecol_q <= '0;
      erow_q <= '0;
      wptr_q <= '0;
      eptr_q <= '0;
    end else begin
      if (do_write) begin
        rcv_q  <= CNT_W'(rcv_inc);
        wptr_q <= (wptr_q == AW'(HIST_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (out_load) begin
        if (frame_end) begin
          rcv_q  <= '0;
          m_q    <= '0;
          ecol_q <= '0;
          erow_q <= '0;
          wptr_q <= '0;
          eptr_q <= '0;
        end else begin
          m_q    <= m_q + 1'b1;
          eptr_q <= a_r;
          if (has_right) begin
            ecol_q <= ecol_q + 1'b1;
          end else begin
            ecol_q <= '0;
            erow_q <= erow_q + 1'b1;
          end
        end
      end
    end
  end

  // Neighbor pack capture
  always_ff @(posedge clk_i) begin
    if (emit_now) dn_q <= pack_bits_i;
    if (state_q == SQ_RD_L) cen_q <= rd_data;
    if (state_q == SQ_RD_R) lft_q <= rd_data;
    if (state_q == SQ_RD_U) rgt_q <= rd_data;
    if (state_q == SQ_CAP)  up_q  <= rd_data;
  end

  for (genvar k = 0; k < PPK; k++) begin : g_lane
    localparam logic [1:0] KI = 2'(k);
    localparam logic [1:0] KL = 2'((k + PPK - 1) % PPK);
    localparam logic [1:0] KR = 2'((k + 1) % PPK);
    nbr_mask_t msk;

    assign msk.nb_left  = (k > 0) || has_left;
    assign msk.nb_right = (k < PPK - 1) || has_right;
    assign msk.nb_up    = has_up;
    assign msk.nb_down  = has_down;

    pbg_lane u_lane (
      .cen_i   (pack_pix(cen_q, KI)),
      .lft_i   (pack_pix((k == 0) ? lft_q : cen_q, KL)),
      .rgt_i   (pack_pix((k == PPK - 1) ? rgt_q : cen_q, KR)),
      .up_i    (pack_pix(up_q, KI)),
      .dn_i    (pack_pix(dn_q, KI)),
      .mask_i  (msk),
      .green_i (erow_q[0] ^ KI[0]),
      .gray_o  (lane_gray[k])
    );
  end

  // Merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < PPK; i++) begin
        gray_q[i] <= lane_gray[i];
      end
      last_q <= frame_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gray0_o      = gray_q[0];
  assign gray1_o      = gray_q[1];
  assign gray2_o      = gray_q[2];
  assign gray3_o      = gray_q[3];
  assign frame_last_o = last_q;

  a_rcv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcv_q <= total)
    else $error("received count beyond frame size");

  a_emit_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SQ_IDLE) |-> (m_q < rcv_q))
    else $error("emitting a pack not yet received");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecol_q) < 32'(eff_w))
    else $error("emit column beyond row width");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && frame_end) |=> (rcv_q == '0 && m_q == '0 && state_q == SQ_IDLE))
    else $error("counters not restarted after frame end");

endmodule

>>> bench/packed_raw10_bayer_to_gray_test.sv
// Self-checking testbench for the packed RAW10 BGGR to gray block: directed and random frames.
module packed_raw10_bayer_to_gray_test import pbg_pkg::*; ();

  localparam int unsigned HIST_DEPTH   = 2 * MAX_WIDTH_PACKS_DEF + 1;
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned ITEM_BUDGET  = 1550;
  localparam int unsigned BIG_PACKS    = 2 * MAX_WIDTH_PACKS_DEF + 20;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PPK-1:0][GRAY_W-1:0] gray;
    logic                       last;
  } gray_res_t;

  class gray_tracker;
    logic [PACK_W-1:0] ring [HIST_DEPTH];
    logic [WP_W-1:0]   width_reg;
    logic [HR_W-1:0]   height_reg;
    int unsigned       taken, col, row;
    gray_res_t         due_grays[$];
    int unsigned       errors, packs, flushes, checked, frames, writes;

    function new();
      width_reg  = WP_RST;
      height_reg = HR_RST;
      restart();
    endfunction

    function void restart();
      taken = 0;
      col   = 0;
      row   = 0;
    endfunction

    function int unsigned cols();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_PACKS_DEF) return MAX_WIDTH_PACKS_DEF;
      return width_reg;
    endfunction

    function int unsigned rows();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      if (idx == CFG_WIDTH_PACKS) begin
        width_reg = data[WP_W-1:0];
        restart();
      end else if (idx == CFG_HEIGHT_ROWS) begin
        height_reg = data[HR_W-1:0];
        restart();
      end
    endfunction

    function int unsigned pixel(int unsigned r, int unsigned x, int unsigned w);
      logic [PACK_W-1:0] p;
      p = ring[(r * w + x / PPK) % HIST_DEPTH] >> (PIX_W * (PPK - 1 - x % PPK));
      return p[PIX_W-1:0];
    endfunction

    // blue/red sites average their in-frame green neighbors
    function logic [GRAY_W-1:0] gray_at(int unsigned r, int unsigned x, int unsigned w,
                                        int unsigned h);
      int unsigned v, sum, cnt;
      v = pixel(r, x, w);
      if (((r + x) % 2) == 0) begin
        sum = 0;
        cnt = 0;
        if (x > 0) begin
          sum += pixel(r, x - 1, w);
          cnt++;
        end
        if (x + 1 < w * PPK) begin
          sum += pixel(r, x + 1, w);
          cnt++;
        end
        if (r > 0) begin
          sum += pixel(r - 1, x, w);
          cnt++;
        end
        if (r + 1 < h) begin
          sum += pixel(r + 1, x, w);
          cnt++;
        end
        if (cnt != 0) v = sum / cnt;
      end
      v = v >> (PIX_W - GRAY_W);
      return v[GRAY_W-1:0];
    endfunction

    function void emit(int unsigned w, int unsigned h);
      gray_res_t res;
      int unsigned pos;
      pos = row * w + col;
      for (int unsigned k = 0; k < PPK; k++) res.gray[k] = gray_at(row, col * PPK + k, w, h);
      res.last = (pos + 1 == w * h);
      due_grays = {due_grays, res};
      if (res.last) begin
        frames++;
        restart();
      end else begin
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void take_item(logic op, logic [PACK_W-1:0] bits);
      int unsigned w, h, pos;
      w   = cols();
      h   = rows();
      pos = row * w + col;
      if (op == OP_DATA) begin
        if (taken < w * h) begin
          ring[taken % HIST_DEPTH] = bits;
          taken++;
          packs++;
          if (taken > w && pos + w < taken) emit(w, h);
        end
      end else if (taken >= w * h && pos < w * h) begin
        flushes++;
        emit(w, h);
      end
    endfunction

    function void check(gray_res_t got);
      gray_res_t want;
      checked++;
      if (due_grays.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual gray %h last %b",
                 $time, got.gray, got.last);
        return;
      end
      want = due_grays.pop_front();
      for (int unsigned k = 0; k < PPK; k++) begin
        if (got.gray[k] !== want.gray[k]) begin
          errors++;
          $display("%0t: gray%0d expected %0d actual %0d", $time, k, want.gray[k], got.gray[k]);
        end
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: frame_last expected %b actual %b", $time, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return due_grays.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_WIDTH_PACKS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  op_i        = OP_DATA;
  logic [PACK_W-1:0]     pack_bits_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [GRAY_W-1:0]     gray0_o, gray1_o, gray2_o, gray3_o;
  logic                  frame_last_o;

  gray_tracker tracker = new();
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 59;
  int unsigned hold_reqs     = 0;
  int unsigned counted       = 0;

  packed_raw10_bayer_to_gray u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .pack_bits_i  (pack_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .gray0_o      (gray0_o),
    .gray1_o      (gray1_o),
    .gray2_o      (gray2_o),
    .gray3_o      (gray3_o),
    .frame_last_o (frame_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        tracker.check({gray3_o, gray2_o, gray1_o, gray0_o, frame_last_o});
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) tracker.take_item(op_i, pack_bits_i);
    end
  end

  // output side: random stall, or a long hold-off when asked
  initial begin : receiver
    int unsigned seen;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [PACK_W-1:0] rand_pack();
    logic [63:0]       r;
    logic [PACK_W-1:0] p;
    r = {$urandom, $urandom};
    p = r[PACK_W-1:0];
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      2: begin
        for (int k = 0; k < PPK; k++) p[k * PIX_W +: PIX_W] = $urandom_range(1) ? '1 : '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_item(input logic op, input logic [PACK_W-1:0] bits);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    pack_bits_i <= bits;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit keep_valid);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!keep_valid) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] wdata, input logic [CFG_DATA_W-1:0] hdata);
    wait_idle();
    cfg_write(CFG_WIDTH_PACKS, wdata, 1'b1);
    cfg_write(CFG_HEIGHT_ROWS, hdata, 1'b0);
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h);
    int unsigned kind, n;
    kind = $urandom_range(9);
    if (kind < 7) begin
      for (int unsigned i = 0; i < w * h; i++) begin
        if ($urandom_range(19) == 0) send_item(OP_DRAIN, rand_pack());
        if ($urandom_range(199) == 0) wait_idle();
        send_item(OP_DATA, rand_pack());
      end
      if ($urandom_range(4) == 0) send_item(OP_DATA, rand_pack());
      for (int unsigned i = 0; i < w; i++) send_item(OP_DRAIN, rand_pack());
      if ($urandom_range(4) == 0) send_item(OP_DRAIN, rand_pack());
      counted += w * h + w;
    end else if (kind < 9) begin
      // truncated frame, later items carry on from here
      n = $urandom_range(w * h);
      for (int unsigned i = 0; i < n; i++) send_item(OP_DATA, rand_pack());
      counted += n;
    end else begin
      repeat ($urandom_range(1, 6))
        send_item($urandom_range(1) ? OP_DRAIN : OP_DATA, rand_pack());
    end
  endtask

  task automatic run_segment();
    int unsigned w, h;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    w = ($urandom_range(7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    h = (w > 6) ? $urandom_range(1, 4) :
        ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    wdata = CFG_DATA_W'(w);
    hdata = CFG_DATA_W'(h);
    if (w == 1 && $urandom_range(3) == 0) wdata = '0;
    if (h == 1 && $urandom_range(3) == 0) hdata = '0;
    wdata[CFG_DATA_W-1:WP_W] = 2'($urandom_range(3));
    set_frame(wdata, hdata);
    repeat ($urandom_range(1, 3)) run_frame(w, h);
  endtask

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one pack per frame; write bits above the width field
    set_frame(CFG_DATA_W'(12'h400), '0);
    send_item(OP_DATA, '1);
    send_item(OP_DATA, '0);
    send_item(OP_DRAIN, '0);
    send_item(OP_DRAIN, '1);

    set_frame(CFG_DATA_W'(2), CFG_DATA_W'(3));
    send_item(OP_DRAIN, rand_pack());
    send_item(OP_DATA, '0);
    send_item(OP_DATA, '1);
    send_item(OP_DATA, 40'hAA_AAAA_AAAA);
    send_item(OP_DATA, 40'h55_5555_5555);
    send_item(OP_DATA, rand_pack());
    send_item(OP_DATA, rand_pack());
    send_item(OP_DATA, rand_pack());
    send_item(OP_DRAIN, rand_pack());
    send_item(OP_DRAIN, rand_pack());
    send_item(OP_DRAIN, rand_pack());

    // unused index must leave the frame alone
    set_frame(CFG_DATA_W'(1), CFG_DATA_W'(2));
    send_item(OP_DATA, rand_pack());
    wait_idle();
    cfg_write(CFG_SPARE, '1, 1'b0);
    send_item(OP_DATA, rand_pack());
    send_item(OP_DRAIN, rand_pack());

    set_frame(CFG_DATA_W'(1), CFG_DATA_W'(MAX_HEIGHT_DEF));
    repeat (4) send_item(OP_DATA, rand_pack());
    set_frame(CFG_DATA_W'(1023), CFG_DATA_W'(MAX_HEIGHT_DEF));
    repeat (3) send_item(OP_DATA, rand_pack());

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = counted + (ITEM_BUDGET - BIG_PACKS) / 3;
      if (ph == 0) begin
        set_frame(CFG_DATA_W'(3), CFG_DATA_W'(8));
        hold_reqs <= hold_reqs + 1;
        repeat (24) send_item(OP_DATA, rand_pack());
        repeat (3) send_item(OP_DRAIN, rand_pack());
        counted += 27;
      end
      if (ph == 2) begin
        // widest row, tallest clamp, history wraps
        set_frame(CFG_DATA_W'(MAX_WIDTH_PACKS_DEF), CFG_DATA_W'(4095));
        for (int unsigned i = 0; i < BIG_PACKS; i++) begin
          if (i == MAX_WIDTH_PACKS_DEF + 80) hold_reqs <= hold_reqs + 1;
          send_item(OP_DATA, rand_pack());
        end
        counted += BIG_PACKS;
        goal    += BIG_PACKS;
      end
      while (counted < goal) run_segment();
    end

    wait_idle();
    $display("Covered %0d packs, %0d drain flushes, %0d whole frames, %0d register writes;",
             tracker.packs, tracker.flushes, tracker.frames, tracker.writes);
    $display("%0d results checked over three idle mixes with two long output hold-offs.",
             tracker.checked);
    if (tracker.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout with %0d results still due", tracker.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
